FILE: rtl/aie_pkg.sv
// Shared types, constants and codes of the accumulator instruction executor.
package aie_pkg;

  localparam int WORD_BITS = 20;
  localparam int MEM_DEPTH = 64;
  localparam int ADDR_BITS = $clog2(MEM_DEPTH);

  localparam int CMD_BITS     = 5;
  localparam int MODE_BITS    = 2;
  localparam int IN_TDATA_W   = 32;
  localparam int OUT_TDATA_W  = 48;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [ADDR_BITS-1:0] addr_t;

  typedef enum logic [CMD_BITS-1:0] {
    OP_AND  = 5'd0,
    OP_ADD  = 5'd1,
    OP_LDA  = 5'd2,
    OP_STA  = 5'd3,
    OP_ISZ  = 5'd4,
    OP_NAND = 5'd5,
    OP_SWP  = 5'd6,
    OP_MUL  = 5'd7,
    OP_SUB  = 5'd8,
    OP_CLA  = 5'd9,
    OP_CLE  = 5'd10,
    OP_CMA  = 5'd11,
    OP_CME  = 5'd12,
    OP_INC  = 5'd13,
    OP_DEC  = 5'd14,
    OP_SPA  = 5'd15,
    OP_SNA  = 5'd16,
    OP_SZA  = 5'd17,
    OP_SZE  = 5'd18,
    OP_IND  = 5'd19,
    OP_HLT  = 5'd20
  } opcode_t;

  localparam logic [MODE_BITS-1:0] MODE_DIRECT   = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_INDIRECT = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_IMM      = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD1,
    ST_RD2
  } state_t;

  // Architectural state and store write produced by one instruction.
  typedef struct packed {
    word_t acc;
    word_t dr;
    word_t tr;
    logic  e;
    logic  skip;
    logic  halt;
    logic  wr_en;
    word_t wr_data;
  } exec_res_t;

endpackage

FILE: rtl/aie_store.sv
// Word store: synchronous one-read one-write memory with reset-cleared valid bits.
module aie_store
  import aie_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  rd_en,
  input  addr_t rd_addr,
  output word_t rd_data,
  input  logic  wr_en,
  input  addr_t wr_addr,
  input  word_t wr_data
);

  word_t store_mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] vld_r;
  word_t rd_data_r;
  logic  rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // A read of the entry being written in the same cycle returns the new word.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
        rd_vld_r  <= 1'b1;
      end else begin
        rd_data_r <= store_mem[rd_addr];
        rd_vld_r  <= vld_r[rd_addr];
      end
    end
  end

  // Entries never written since reset read as zero.
  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

FILE: rtl/aie_exec.sv
// Instruction execute logic: next register values, skip test and store write.
module aie_exec
  import aie_pkg::*;
(
  input  logic [CMD_BITS-1:0]  cmd,
  input  logic [MODE_BITS-1:0] mode,
  input  word_t                operand,
  input  word_t                mem_data,
  input  word_t                acc,
  input  word_t                dr,
  input  word_t                tr,
  input  logic                 e,
  input  logic                 halt,
  output exec_res_t            res
);

  logic                   imm;
  word_t                  fetched;
  word_t                  fetched_inc;
  logic [2*WORD_BITS-1:0] prod;

  assign imm         = (mode == MODE_IMM);
  assign fetched     = imm ? operand : mem_data;
  assign fetched_inc = fetched + word_t'(1);
  assign prod        = acc * fetched;

  always_comb begin
    res         = '0;
    res.acc     = acc;
    res.dr      = dr;
    res.tr      = tr;
    res.e       = e;
    res.halt    = halt;
    res.wr_data = acc;
    if (!halt) begin
      unique case (opcode_t'(cmd))
        OP_AND: begin
          res.dr  = fetched;
          res.acc = acc & fetched;
        end
        OP_ADD: begin
          res.dr  = fetched;
          res.acc = acc + fetched;
        end
        OP_LDA: res.acc = fetched;
        OP_STA: res.wr_en = !imm;
        OP_ISZ: begin
          res.dr      = fetched_inc;
          res.wr_en   = !imm;
          res.wr_data = fetched_inc;
          res.skip    = (fetched_inc == '0);
        end
        OP_NAND: begin
          res.dr  = fetched;
          res.acc = ~(acc & fetched);
        end
        OP_SWP: begin
          if (!imm) begin
            res.tr    = acc;
            res.acc   = mem_data;
            res.wr_en = 1'b1;
          end
        end
        OP_MUL: begin
          res.dr  = fetched;
          res.acc = prod[WORD_BITS-1:0];
        end
        OP_SUB: begin
          res.dr  = fetched;
          res.acc = acc - fetched;
        end
        OP_CLA:  res.acc  = '0;
        OP_CLE:  res.e    = 1'b0;
        OP_CMA:  res.acc  = ~acc;
        OP_CME:  res.e    = ~e;
        OP_INC:  res.acc  = acc + word_t'(1);
        OP_DEC:  res.acc  = acc - word_t'(1);
        OP_SPA:  res.skip = ~acc[WORD_BITS-1];
        OP_SNA:  res.skip = acc[WORD_BITS-1];
        OP_SZA:  res.skip = (acc == '0);
        OP_SZE:  res.skip = ~e;
        OP_IND:  res.dr   = dr + word_t'(1);
        OP_HLT:  res.halt = 1'b1;
        default: res.skip = 1'b0;
      endcase
    end
  end

endmodule

FILE: rtl/accumulator_instruction_executor_top.sv
// Top level of the accumulator instruction executor: sequencer, registers, result stage.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_tvalid/in_tready   | in_tdata  : cmd, addr_mode, operand
//   out_    | output    | out_tvalid/out_tready | out_tdata : acc, DR, E, skip, halted
//
// An instruction completes in state ST_RD1 (direct, immediate or register operation) or
// in state ST_RD2 (indirect), set by the single synchronous read port of the store: the
// pointer read must return before the operand read can start.
// The next transaction is accepted in the cycle an instruction completes, so direct
// instructions stream at one per cycle unless the output stalls; indirect ones do not.
// Reset clears the registers and the store's valid bits at once; no sweep.
// A result waiting in the output register stalls completion only, not the store read.
module accumulator_instruction_executor_top
  import aie_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [4:0] cmd, [6:5] addr_mode, [26:7] operand, [31:27] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [19:0] acc_value, [39:20] data_reg, [40] extend_bit, [41] skip_next,
  // [42] halted, [47:43] zero
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  state_t state_r, state_nxt;

  logic [CMD_BITS-1:0]  cmd_r;
  logic [MODE_BITS-1:0] mode_r;
  word_t                opnd_r;
  addr_t                ea_r;

  word_t acc_r, dr_r, tr_r;
  logic  e_r, halt_r;

  logic  out_valid_r;
  word_t out_acc_r, out_dr_r;
  logic  out_e_r, out_skip_r, out_halt_r;

  logic      accept, out_free, exec_now, fire;
  logic      rd_en;
  addr_t     rd_addr, wr_addr;
  word_t     mem_data;
  exec_res_t res;

  assign accept   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign exec_now = ((state_r == ST_RD1) && (mode_r != MODE_INDIRECT)) ||
                    (state_r == ST_RD2);
  assign fire     = exec_now && out_free;
  assign in_tready = (state_r == ST_IDLE) || fire;

  // The pointer read of an indirect operand follows the address read directly.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = in_tdata[7 +: ADDR_BITS];
    if (accept) begin
      rd_en = 1'b1;
    end else if ((state_r == ST_RD1) && (mode_r == MODE_INDIRECT)) begin
      rd_en   = 1'b1;
      rd_addr = mem_data[ADDR_BITS-1:0];
    end
  end

  assign wr_addr = (state_r == ST_RD2) ? ea_r : opnd_r[ADDR_BITS-1:0];

  aie_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (mem_data),
    .wr_en   (fire && res.wr_en),
    .wr_addr (wr_addr),
    .wr_data (res.wr_data)
  );

  aie_exec u_exec (
    .cmd      (cmd_r),
    .mode     (mode_r),
    .operand  (opnd_r),
    .mem_data (mem_data),
    .acc      (acc_r),
    .dr       (dr_r),
    .tr       (tr_r),
    .e        (e_r),
    .halt     (halt_r),
    .res      (res)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_RD1;
        end
      end
      ST_RD1: begin
        if (mode_r == MODE_INDIRECT) begin
          state_nxt = ST_RD2;
        end else if (fire) begin
          state_nxt = accept ? ST_RD1 : ST_IDLE;
        end
      end
      ST_RD2: begin
        if (fire) begin
          state_nxt = accept ? ST_RD1 : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_tdata[4:0];
      mode_r <= in_tdata[6:5];
      opnd_r <= in_tdata[26:7];
    end
    if ((state_r == ST_RD1) && (mode_r == MODE_INDIRECT)) begin
      ea_r <= mem_data[ADDR_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      dr_r   <= '0;
      tr_r   <= '0;
      e_r    <= 1'b0;
      halt_r <= 1'b0;
    end else if (fire) begin
      acc_r  <= res.acc;
      dr_r   <= res.dr;
      tr_r   <= res.tr;
      e_r    <= res.e;
      halt_r <= res.halt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_acc_r  <= res.acc;
      out_dr_r   <= res.dr;
      out_e_r    <= res.e;
      out_skip_r <= res.skip;
      out_halt_r <= res.halt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_halt_r, out_skip_r, out_e_r, out_dr_r, out_acc_r};

endmodule

FILE: tb/accumulator_instruction_executor_top_tb.sv
// Self-checking testbench of the accumulator instruction executor.
`timescale 1ns / 100ps

module accumulator_instruction_executor_top_tb;
  import aie_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 6;
  localparam int RANDOM_ITEMS  = 700;
  localparam int N_PHASES      = 3;
  localparam int DRAIN_CYCLES  = 12;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int N_DIRECTED    = 27;
  localparam int N_CLOSING     = 4;

  // Opcodes the block does not decode and the address mode it treats as direct.
  localparam logic [CMD_BITS-1:0]  OP_UNUSED_LOW = 5'd21;
  localparam logic [CMD_BITS-1:0]  OP_UNUSED_TOP = 5'd31;
  localparam logic [MODE_BITS-1:0] MODE_SPARE    = 2'd3;

  typedef struct packed {
    word_t acc;
    word_t dr;
    logic  e;
    logic  skip;
    logic  halt;
  } result_t;

  typedef struct packed {
    logic [CMD_BITS-1:0]  cmd;
    logic [MODE_BITS-1:0] mode;
    word_t                opnd;
    logic                 typed;
    result_t              res;
  } instr_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Machine state as the testbench expects it to be.
  word_t st_acc, st_dr, st_tr;
  logic  st_e, st_halt;
  word_t st_mem [MEM_DEPTH];

  result_t pending_results [$];
  int      send_idle_pct = 21;
  int      recv_idle_pct = 54;
  int      error_count   = 0;
  int      issued_count  = 0;
  int      checked_count = 0;
  int      skip_count    = 0;
  int      cycle_count   = 0;

  // Typed rows were worked out by hand from the reset state; the rest go through the predictor.
  instr_row_t directed_rows [N_DIRECTED] = '{
    '{OP_LDA,  MODE_DIRECT,   20'h00000, 1'b1, '{20'h00000, 20'h0, 1'b0, 1'b0, 1'b0}},
    '{OP_SZA,  MODE_DIRECT,   20'h00000, 1'b1, '{20'h00000, 20'h0, 1'b0, 1'b1, 1'b0}},
    '{OP_SZE,  MODE_IMM,      20'hFFFFF, 1'b1, '{20'h00000, 20'h0, 1'b0, 1'b1, 1'b0}},
    '{OP_CMA,  MODE_DIRECT,   20'h00000, 1'b1, '{20'hFFFFF, 20'h0, 1'b0, 1'b0, 1'b0}},
    '{OP_SNA,  MODE_INDIRECT, 20'h80000, 1'b1, '{20'hFFFFF, 20'h0, 1'b0, 1'b1, 1'b0}},
    '{OP_SPA,  MODE_DIRECT,   20'h00000, 1'b1, '{20'hFFFFF, 20'h0, 1'b0, 1'b0, 1'b0}},
    '{OP_INC,  MODE_DIRECT,   20'h00000, 1'b1, '{20'h00000, 20'h0, 1'b0, 1'b0, 1'b0}},
    '{OP_DEC,  MODE_SPARE,    20'h7FFFF, 1'b1, '{20'hFFFFF, 20'h0, 1'b0, 1'b0, 1'b0}},
    '{OP_CME,  MODE_DIRECT,   20'h00000, 1'b1, '{20'hFFFFF, 20'h0, 1'b1, 1'b0, 1'b0}},
    '{OP_SZE,  MODE_DIRECT,   20'h00000, 1'b1, '{20'hFFFFF, 20'h0, 1'b1, 1'b0, 1'b0}},
    '{OP_CLE,  MODE_DIRECT,   20'h00000, 1'b1, '{20'hFFFFF, 20'h0, 1'b0, 1'b0, 1'b0}},
    '{OP_CLA,  MODE_DIRECT,   20'h00000, 1'b1, '{20'h00000, 20'h0, 1'b0, 1'b0, 1'b0}},
    '{OP_LDA,  MODE_IMM,      20'h7FFFF, 1'b1, '{20'h7FFFF, 20'h0, 1'b0, 1'b0, 1'b0}},
    '{OP_STA,  MODE_DIRECT,   20'h80005, 1'b0, '0},
    '{OP_ADD,  MODE_IMM,      20'h00001, 1'b0, '0},
    '{OP_SUB,  MODE_DIRECT,   20'h00005, 1'b0, '0},
    '{OP_STA,  MODE_INDIRECT, 20'h80005, 1'b0, '0},
    '{OP_ISZ,  MODE_INDIRECT, 20'h00005, 1'b0, '0},
    '{OP_ISZ,  MODE_IMM,      20'hFFFFF, 1'b0, '0},
    '{OP_NAND, MODE_IMM,      20'hF0F0F, 1'b0, '0},
    '{OP_MUL,  MODE_SPARE,    20'h0003F, 1'b0, '0},
    '{OP_AND,  MODE_IMM,      20'hFFFFF, 1'b0, '0},
    '{OP_SWP,  MODE_DIRECT,   20'h00005, 1'b0, '0},
    '{OP_SWP,  MODE_IMM,      20'h12345, 1'b0, '0},
    '{OP_IND,  MODE_DIRECT,   20'h00000, 1'b0, '0},
    '{OP_UNUSED_TOP, MODE_IMM, 20'hFFFFF, 1'b0, '0},
    '{OP_STA,  MODE_IMM,      20'h00000, 1'b0, '0}
  };

  // After the halt every instruction must leave the machine frozen.
  instr_row_t closing_rows [N_CLOSING] = '{
    '{OP_HLT,        MODE_DIRECT, 20'h00000, 1'b0, '0},
    '{OP_LDA,        MODE_IMM,    20'h55555, 1'b0, '0},
    '{OP_SZA,        MODE_DIRECT, 20'h00000, 1'b0, '0},
    '{OP_UNUSED_LOW, MODE_DIRECT, 20'h00000, 1'b0, '0}
  };

  accumulator_instruction_executor_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #(CLK_HALF) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Executes one instruction on the expected machine state and returns what the block shows.
  function automatic result_t execute_instr(logic [CMD_BITS-1:0] cmd,
                                            logic [MODE_BITS-1:0] mode, word_t opnd);
    addr_t   ea;
    word_t   val;
    logic    imm;
    result_t r;
    imm = (mode == MODE_IMM);
    ea  = opnd[ADDR_BITS-1:0];
    if (mode == MODE_INDIRECT)
      ea = st_mem[ea][ADDR_BITS-1:0];
    val    = imm ? opnd : st_mem[ea];
    r.skip = 1'b0;
    if (!st_halt) begin
      case (cmd)
        OP_AND: begin
          st_dr  = val;
          st_acc = st_acc & st_dr;
        end
        OP_ADD: begin
          st_dr  = val;
          st_acc = st_acc + st_dr;
        end
        OP_LDA: st_acc = val;
        OP_STA: if (!imm) st_mem[ea] = st_acc;
        OP_ISZ: begin
          st_dr = val + 1'b1;
          if (!imm)
            st_mem[ea] = st_dr;
          r.skip = (st_dr == '0);
        end
        OP_NAND: begin
          st_dr  = val;
          st_acc = ~(st_acc & st_dr);
        end
        OP_SWP: if (!imm) begin
          st_tr      = st_acc;
          st_acc     = st_mem[ea];
          st_mem[ea] = st_tr;
        end
        OP_MUL: begin
          st_dr  = val;
          st_acc = st_acc * st_dr;
        end
        OP_SUB: begin
          st_dr  = val;
          st_acc = st_acc - st_dr;
        end
        OP_CLA: st_acc = '0;
        OP_CLE: st_e = 1'b0;
        OP_CMA: st_acc = ~st_acc;
        OP_CME: st_e = ~st_e;
        OP_INC: st_acc = st_acc + 1'b1;
        OP_DEC: st_acc = st_acc - 1'b1;
        OP_SPA: r.skip = ~st_acc[WORD_BITS-1];
        OP_SNA: r.skip = st_acc[WORD_BITS-1];
        OP_SZA: r.skip = (st_acc == '0);
        OP_SZE: r.skip = ~st_e;
        OP_IND: st_dr = st_dr + 1'b1;
        OP_HLT: st_halt = 1'b1;
        default: ;
      endcase
    end
    r.acc  = st_acc;
    r.dr   = st_dr;
    r.e    = st_e;
    r.halt = st_halt;
    return r;
  endfunction

  // Presents one instruction, waits for its transaction and records what should come back.
  task automatic issue_instr(instr_row_t row);
    result_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, row.opnd, row.mode, row.cmd};
    do @(posedge clk); while (!in_tready);
    predicted = execute_instr(row.cmd, row.mode, row.opnd);
    pending_results.push_back(row.typed ? row.res : predicted);
    issued_count++;
  endtask

  function automatic instr_row_t random_instr();
    instr_row_t row;
    row       = '0;
    if ($urandom_range(0, 99) < 90)
      row.cmd = CMD_BITS'($urandom_range(0, 19));
    else
      row.cmd = CMD_BITS'($urandom_range(21, 31));
    row.mode  = MODE_BITS'($urandom_range(0, 3));
    case ($urandom_range(0, 11))
      0:       row.opnd = 20'h00000;
      1:       row.opnd = 20'hFFFFF;
      2:       row.opnd = 20'h7FFFF;
      3:       row.opnd = 20'h80000;
      default: row.opnd = word_t'($urandom);
    endcase
    return row;
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.acc  = out_tdata[19:0];
      got.dr   = out_tdata[39:20];
      got.e    = out_tdata[40];
      got.skip = out_tdata[41];
      got.halt = out_tdata[42];
      if (pending_results.size() == 0) begin
        $error("Result transaction with no instruction outstanding: %h", out_tdata);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        checked_count++;
        if (got.skip)
          skip_count++;
        if (got.acc !== want.acc) begin
          $error("acc_value: expected %h, got %h", want.acc, got.acc);
          error_count++;
        end
        if (got.dr !== want.dr) begin
          $error("data_reg: expected %h, got %h", want.dr, got.dr);
          error_count++;
        end
        if (got.e !== want.e) begin
          $error("extend_bit: expected %b, got %b", want.e, got.e);
          error_count++;
        end
        if (got.skip !== want.skip) begin
          $error("skip_next: expected %b, got %b", want.skip, got.skip);
          error_count++;
        end
        if (got.halt !== want.halt) begin
          $error("halted: expected %b, got %b", want.halt, got.halt);
          error_count++;
        end
      end
    end
  end

  initial begin
    st_acc  = '0;
    st_dr   = '0;
    st_tr   = '0;
    st_e    = 1'b0;
    st_halt = 1'b0;
    foreach (st_mem[k])
      st_mem[k] = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[k])
      issue_instr(directed_rows[k]);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 21;
          recv_idle_pct = 54;
        end
        1: begin
          send_idle_pct = 54;
          recv_idle_pct = 21;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int i = 0; i < RANDOM_ITEMS / N_PHASES; i++)
        issue_instr(random_instr());
      // After the first phase, hold the input off until the output side has caught up completely.
      if (ph == 0) begin
        in_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
    end

    foreach (closing_rows[k])
      issue_instr(closing_rows[k]);

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d instructions (%0d from the directed table) ending with a halt;",
             issued_count, N_DIRECTED + N_CLOSING);
    $display("%0d results checked, %0d with skip_next set, %0d mismatches.",
             checked_count, skip_count, error_count);
    if (error_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
